[src/ftan_pkg.sv]
// Shared types and fixed widths for the face tangent pipeline.
// No dependencies; imported by face_tangent_from_edge and ftan_norm.
package ftan_pkg;

  // Width of one packed component and of one packed xyz vector.
  localparam int COMP_BITS = 16;
  localparam int VEC_BITS  = 3 * COMP_BITS;

  // The largest normalized magnitude sits in [2^23, 2^24).
  localparam int NORM_BITS = 24;
  // Sum of three squared normalized magnitudes, and its integer root.
  localparam int SQ_BITS   = 2 * NORM_BITS + 2;
  localparam int ROOT_BITS = SQ_BITS / 2;

  typedef struct packed {
    logic [VEC_BITS-1:0] edge_start;
    logic [VEC_BITS-1:0] edge_end;
    logic [VEC_BITS-1:0] normal_a;
    logic [VEC_BITS-1:0] normal_b;
    logic [VEC_BITS-1:0] normal_c;
  } ftan_in_t;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] tangent_x;
    logic signed [COMP_BITS-1:0] tangent_y;
    logic signed [COMP_BITS-1:0] tangent_z;
    logic                        degenerate;
  } ftan_out_t;

endpackage

[src/face_tangent_from_edge.sv]
// Face tangent pipeline: top level.
// Depends on ftan_pkg, ftan_norm and ftan_proj.
//
// Usage: one triangle face enters per request on the in_ channel (valid and
// ready): two corner positions and three corner normals, each a packed xyz
// of signed 16-bit components. The out_ channel returns one request per
// face with the tangent in signed Q1.FRACTION_BITS and a degenerate flag.
// The path runs through a normalizer pass, 4 projection stages and a
// second normalizer pass; each pass is built around the 25-stage square
// root and the one-bit-per-stage divider. Every stage holds its own valid bit.
// Throughput is one face per cycle while the receiver does not stall.
// Reset clears all valid bits, so the pipeline starts empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops in the same cycle; nothing is lost or repeated.
module face_tangent_from_edge #(
  parameter int FRACTION_BITS = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ftan_pkg::ftan_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ftan_pkg::ftan_out_t out_data
);
  import ftan_pkg::*;

  localparam int RW   = FRACTION_BITS + 2;
  localparam int NS_W = COMP_BITS + 2;
  localparam int ED_W = COMP_BITS + 1;
  localparam int TW   = 3 * FRACTION_BITS + 4;

  logic en;

  // Unpack components; sum the normals and form the edge.
  logic [2:0][NS_W-1:0] ns_vec;
  logic [2:0][ED_W-1:0] ed_vec;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ns_vec[i] = NS_W'($signed(in_data.normal_a[i*COMP_BITS +: COMP_BITS]))
                + NS_W'($signed(in_data.normal_b[i*COMP_BITS +: COMP_BITS]))
                + NS_W'($signed(in_data.normal_c[i*COMP_BITS +: COMP_BITS]));
      ed_vec[i] = ED_W'($signed(in_data.edge_end[i*COMP_BITS +: COMP_BITS]))
                - ED_W'($signed(in_data.edge_start[i*COMP_BITS +: COMP_BITS]));
    end
  end

  // Normal and edge normalize side by side.
  logic               n_valid, e_valid, n_deg, e_deg;
  logic [2:0][RW-1:0] n_vec, e_vec;

  ftan_norm #(.IN_W(NS_W), .FRAC(FRACTION_BITS)) u_norm_n (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_vec   (ns_vec),
    .in_deg   (1'b0),
    .out_valid(n_valid),
    .out_vec  (n_vec),
    .out_deg  (n_deg)
  );

  ftan_norm #(.IN_W(ED_W), .FRAC(FRACTION_BITS)) u_norm_e (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_vec   (ed_vec),
    .in_deg   (1'b0),
    .out_valid(e_valid),
    .out_vec  (e_vec),
    .out_deg  (e_deg)
  );

  // Remove the edge's component along the normal.
  logic               p_valid, p_deg;
  logic [2:0][TW-1:0] p_t;

  ftan_proj #(.FRAC(FRACTION_BITS)) u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (n_valid & e_valid),
    .in_n     (n_vec),
    .in_e     (e_vec),
    .in_deg   (n_deg | e_deg),
    .out_valid(p_valid),
    .out_t    (p_t),
    .out_deg  (p_deg)
  );

  // Final normalization; its last stage is the output register.
  logic               t_valid, t_deg;
  logic [2:0][RW-1:0] t_vec;

  ftan_norm #(.IN_W(TW), .FRAC(FRACTION_BITS)) u_norm_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p_valid),
    .in_vec   (p_t),
    .in_deg   (p_deg),
    .out_valid(t_valid),
    .out_vec  (t_vec),
    .out_deg  (t_deg)
  );

  // The pipeline advances unless a finished result is held by the receiver.
  assign en        = !t_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = t_valid;

  assign out_data.tangent_x  = COMP_BITS'($signed(t_vec[0]));
  assign out_data.tangent_y  = COMP_BITS'($signed(t_vec[1]));
  assign out_data.tangent_z  = COMP_BITS'($signed(t_vec[2]));
  assign out_data.degenerate = t_deg;

  // The two parallel normalizers stay in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    n_valid == e_valid)
    else $error("normal and edge normalizers out of step");

  // A result without the degenerate flag is never the zero vector.
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate |->
      (out_data.tangent_x != '0) || (out_data.tangent_y != '0) ||
      (out_data.tangent_z != '0))
    else $error("nondegenerate result is the zero vector");

  // The x component stays within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ($signed(t_vec[0]) <= $signed(RW'(1) << FRACTION_BITS)) &&
      ($signed(t_vec[0]) >= -$signed(RW'(1) << FRACTION_BITS)))
    else $error("tangent x component out of range");

endmodule

[src/ftan_norm.sv]
// Pipelined fixed-point normalizer for a signed integer xyz vector.
// Depends on ftan_pkg (NORM_BITS, SQ_BITS, ROOT_BITS).
module ftan_norm #(
  parameter int IN_W = 18,
  parameter int FRAC = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0][IN_W-1:0]   in_vec,
  input  logic                   in_deg,
  output logic                   out_valid,
  output logic [2:0][FRAC+1:0]   out_vec,
  output logic                   out_deg
);
  import ftan_pkg::*;

  localparam int RW    = FRAC + 2;
  localparam int SH_W  = $clog2(IN_W + 1);
  localparam int QB    = FRAC + 1;
  localparam int NUM_W = NORM_BITS + FRAC + 1;
  localparam int REM_W = ROOT_BITS + 3;
  localparam int WIDE_W = IN_W + NORM_BITS;

  // Stage A: magnitudes, signs and the largest magnitude.
  logic [2:0][IN_W-1:0] sa_mag_nxt, sa_mag_r;
  logic [2:0]           sa_sgn_nxt, sa_sgn_r;
  logic [IN_W-1:0]      sa_max_nxt, sa_max_r;
  logic                 sa_valid_r, sa_deg_r;

  always_comb begin
    sa_max_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      sa_sgn_nxt[i] = in_vec[i][IN_W-1];
      sa_mag_nxt[i] = sa_sgn_nxt[i] ? (~in_vec[i] + 1'b1) : in_vec[i];
      if (sa_mag_nxt[i] > sa_max_nxt) begin
        sa_max_nxt = sa_mag_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else if (en) begin
      sa_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_mag_r <= sa_mag_nxt;
      sa_sgn_r <= sa_sgn_nxt;
      sa_max_r <= sa_max_nxt;
      sa_deg_r <= in_deg;
    end
  end

  // Stage B: leading-one search sets the common shift.
  logic [SH_W-1:0]      sb_shift_nxt, sb_shift_r;
  logic                 sb_zero_nxt, sb_zero_r;
  logic [2:0][IN_W-1:0] sb_mag_r;
  logic [2:0]           sb_sgn_r;
  logic                 sb_valid_r, sb_deg_r;

  always_comb begin
    sb_shift_nxt = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (sa_max_r[b]) begin
        sb_shift_nxt = SH_W'(b + 1);
      end
    end
    sb_zero_nxt = (sa_max_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
    end else if (en) begin
      sb_valid_r <= sa_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_shift_r <= sb_shift_nxt;
      sb_zero_r  <= sb_zero_nxt;
      sb_mag_r   <= sa_mag_r;
      sb_sgn_r   <= sa_sgn_r;
      sb_deg_r   <= sa_deg_r;
    end
  end

  // Stage C: place the leading one of the largest magnitude at the top bit.
  logic [2:0][WIDE_W-1:0]    sc_wide;
  logic [2:0][NORM_BITS-1:0] sc_a_nxt, sc_a_r;
  logic [2:0]                sc_sgn_r;
  logic                      sc_valid_r, sc_zero_r, sc_deg_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sc_wide[i]  = {sb_mag_r[i], {NORM_BITS{1'b0}}};
      sc_a_nxt[i] = NORM_BITS'(sc_wide[i] >> sb_shift_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (en) begin
      sc_valid_r <= sb_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_a_r    <= sc_a_nxt;
      sc_sgn_r  <= sb_sgn_r;
      sc_zero_r <= sb_zero_r;
      sc_deg_r  <= sb_deg_r;
    end
  end

  // Stage D: squares of the normalized magnitudes.
  logic [2:0][2*NORM_BITS-1:0] sd_sq_nxt, sd_sq_r;
  logic [2:0][NORM_BITS-1:0]   sd_a_r;
  logic [2:0]                  sd_sgn_r;
  logic                        sd_valid_r, sd_zero_r, sd_deg_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd_sq_nxt[i] = (2*NORM_BITS)'(sc_a_r[i]) * (2*NORM_BITS)'(sc_a_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd_valid_r <= 1'b0;
    end else if (en) begin
      sd_valid_r <= sc_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_sq_r   <= sd_sq_nxt;
      sd_a_r    <= sc_a_r;
      sd_sgn_r  <= sc_sgn_r;
      sd_zero_r <= sc_zero_r;
      sd_deg_r  <= sc_deg_r;
    end
  end

  // Square root pipeline, two radicand bits per stage; entry 0 holds the sum.
  logic [SQ_BITS-1:0]        qx_r    [0:ROOT_BITS];
  logic [REM_W-1:0]          qrem_r  [0:ROOT_BITS];
  logic [ROOT_BITS-1:0]      qroot_r [0:ROOT_BITS];
  logic [2:0][NORM_BITS-1:0] qa_r    [0:ROOT_BITS];
  logic [2:0]                qsgn_r  [0:ROOT_BITS];
  logic                      qzero_r [0:ROOT_BITS];
  logic                      qdeg_r  [0:ROOT_BITS];
  logic                      qvalid_r[0:ROOT_BITS];
  logic [SQ_BITS-1:0]        se_sum_nxt;

  assign se_sum_nxt = SQ_BITS'(sd_sq_r[0]) + SQ_BITS'(sd_sq_r[1]) + SQ_BITS'(sd_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qvalid_r[0] <= 1'b0;
    end else if (en) begin
      qvalid_r[0] <= sd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r[0]    <= se_sum_nxt;
      qrem_r[0]  <= '0;
      qroot_r[0] <= '0;
      qa_r[0]    <= sd_a_r;
      qsgn_r[0]  <= sd_sgn_r;
      qzero_r[0] <= sd_zero_r;
      qdeg_r[0]  <= sd_deg_r;
    end
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fit;

    assign rem_sh = {qrem_r[k][REM_W-3:0], qx_r[k][SQ_BITS-1 -: 2]};
    assign trial  = REM_W'({qroot_r[k], 2'b01});
    assign fit    = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qvalid_r[k+1] <= 1'b0;
      end else if (en) begin
        qvalid_r[k+1] <= qvalid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qx_r[k+1]    <= qx_r[k] << 2;
        qrem_r[k+1]  <= fit ? (rem_sh - trial) : rem_sh;
        qroot_r[k+1] <= {qroot_r[k][ROOT_BITS-2:0], fit};
        qa_r[k+1]    <= qa_r[k];
        qsgn_r[k+1]  <= qsgn_r[k];
        qzero_r[k+1] <= qzero_r[k];
        qdeg_r[k+1]  <= qdeg_r[k];
      end
    end
  end

  // Division pipeline, one quotient bit per stage; entry 0 holds the
  // rounded numerators a * 2^FRAC + floor(L / 2).
  logic [2:0][NUM_W-1:0] dr_r    [0:QB];
  logic [2:0][QB-1:0]    dq_r    [0:QB];
  logic [ROOT_BITS-1:0]  dl_r    [0:QB];
  logic [2:0]            dsgn_r  [0:QB];
  logic                  dzero_r [0:QB];
  logic                  ddeg_r  [0:QB];
  logic                  dvalid_r[0:QB];
  logic [2:0][NUM_W-1:0] dn_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn_nxt[i] = NUM_W'({qa_r[ROOT_BITS][i], {FRAC{1'b0}}})
                + NUM_W'(qroot_r[ROOT_BITS] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r[0] <= 1'b0;
    end else if (en) begin
      dvalid_r[0] <= qvalid_r[ROOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr_r[0]    <= dn_nxt;
      dq_r[0]    <= '0;
      dl_r[0]    <= qroot_r[ROOT_BITS];
      dsgn_r[0]  <= qsgn_r[ROOT_BITS];
      dzero_r[0] <= qzero_r[ROOT_BITS];
      ddeg_r[0]  <= qdeg_r[ROOT_BITS];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int BIT = FRAC - j;
    logic [NUM_W-1:0] dsub;
    logic [2:0]       fit;

    assign dsub = NUM_W'(dl_r[j]) << BIT;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        fit[i] = (dr_r[j][i] >= dsub);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvalid_r[j+1] <= 1'b0;
      end else if (en) begin
        dvalid_r[j+1] <= dvalid_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dr_r[j+1][i] <= fit[i] ? (dr_r[j][i] - dsub) : dr_r[j][i];
          dq_r[j+1][i] <= {dq_r[j][i][QB-2:0], fit[i]};
        end
        dl_r[j+1]    <= dl_r[j];
        dsgn_r[j+1]  <= dsgn_r[j];
        dzero_r[j+1] <= dzero_r[j];
        ddeg_r[j+1]  <= ddeg_r[j];
      end
    end
  end

  // Final stage: clamp to one, apply signs, force zero for a zero vector.
  logic [QB-1:0]        fin_one;
  logic [2:0][QB-1:0]   fin_q;
  logic [2:0][RW-1:0]   out_vec_nxt, out_vec_r;
  logic                 out_valid_r, out_deg_r;

  assign fin_one = {1'b1, {FRAC{1'b0}}};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin_q[i] = (dq_r[QB][i] > fin_one) ? fin_one : dq_r[QB][i];
      if (dzero_r[QB]) begin
        out_vec_nxt[i] = '0;
      end else if (dsgn_r[QB][i]) begin
        out_vec_nxt[i] = ~RW'(fin_q[i]) + 1'b1;
      end else begin
        out_vec_nxt[i] = RW'(fin_q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dvalid_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vec_r <= out_vec_nxt;
      out_deg_r <= ddeg_r[QB] | dzero_r[QB];
    end
  end

  assign out_valid = out_valid_r;
  assign out_vec   = out_vec_r;
  assign out_deg   = out_deg_r;

  // A nonzero vector always has a root of at least 2^23 after the shift.
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    dvalid_r[0] && !dzero_r[0] |-> dl_r[0][ROOT_BITS-1 -: 2] != 2'b00)
    else $error("normalizer root below expected range");

endmodule

[src/ftan_proj.sv]
// Pipelined Gram-Schmidt step: T = E * 2^(2F) - N * (E . N).
// Uses nothing from ftan_pkg; it has no dependencies.
module ftan_proj #(
  parameter int FRAC = 14
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2:0][FRAC+1:0]     in_n,
  input  logic [2:0][FRAC+1:0]     in_e,
  input  logic                     in_deg,
  output logic                     out_valid,
  output logic [2:0][3*FRAC+3:0]   out_t,
  output logic                     out_deg
);
  localparam int RW  = FRAC + 2;
  localparam int DW  = 2 * RW;
  localparam int NDW = RW + DW;
  localparam int TW  = 3 * FRAC + 4;

  // Stage 1: per-axis products of edge and normal.
  logic signed [DW-1:0] p_nxt [3];
  logic signed [DW-1:0] p_r   [3];
  logic signed [RW-1:0] e1_r  [3];
  logic signed [RW-1:0] n1_r  [3];
  logic                 v1_r, deg1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = DW'($signed(in_e[i])) * DW'($signed(in_n[i]));
    end
  end

  // Stage 2: dot product.
  logic signed [DW-1:0] d_nxt, d_r;
  logic signed [RW-1:0] e2_r [3];
  logic signed [RW-1:0] n2_r [3];
  logic                 v2_r, deg2_r;

  assign d_nxt = p_r[0] + p_r[1] + p_r[2];

  // Stage 3: normal scaled by the dot product.
  logic signed [NDW-1:0] nd_nxt [3];
  logic signed [NDW-1:0] nd_r   [3];
  logic signed [RW-1:0]  e3_r   [3];
  logic                  v3_r, deg3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nd_nxt[i] = NDW'(n2_r[i]) * NDW'(d_r);
    end
  end

  // Stage 4: subtract from the scaled edge.
  logic signed [NDW-1:0] t_full [3];
  logic [2:0][TW-1:0]    t_nxt, t_r;
  logic                  v4_r, deg4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_full[i] = (NDW'(e3_r[i]) <<< (2 * FRAC)) - nd_r[i];
      t_nxt[i]  = TW'(t_full[i]);
    end
  end

  // Valid bits for the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Data registers for the four stages.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i]  <= p_nxt[i];
        e1_r[i] <= $signed(in_e[i]);
        n1_r[i] <= $signed(in_n[i]);
        e2_r[i] <= e1_r[i];
        n2_r[i] <= n1_r[i];
        nd_r[i] <= nd_nxt[i];
        e3_r[i] <= e2_r[i];
      end
      d_r    <= d_nxt;
      t_r    <= t_nxt;
      deg1_r <= in_deg;
      deg2_r <= deg1_r;
      deg3_r <= deg2_r;
      deg4_r <= deg3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_t     = t_r;
  assign out_deg   = deg4_r;

endmodule
